// File: hdl/node_id_local_renumber_top_assert.svh
// assertion macros used by the node id renumber sequencer
`ifndef NODE_ID_LOCAL_RENUMBER_TOP_ASSERT_SVH
`define NODE_ID_LOCAL_RENUMBER_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define NLR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define NLR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/nlr_pkg.sv
// shared constants and types of the node id renumber block
`default_nettype none

package nlr_pkg;

  localparam int CAPACITY = 1024;
  localparam int ID_BITS  = 31;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic MODE_CLEAR  = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  // ring control from the sequencer to the id cells
  typedef struct packed {
    logic shift;
    logic ins;
  } ring_ctl_t;

endpackage

`default_nettype wire

// File: hdl/nlr_if.sv
// valid/ready channel interfaces for input and result words
`default_nettype none

interface nlr_in_if #(
  parameter int ID_W = nlr_pkg::ID_BITS
);
  logic            valid;
  logic            ready;
  logic            mode;
  logic [ID_W-1:0] node_id;

  modport source (output valid, output mode, output node_id, input ready);
  modport sink   (input valid, input mode, input node_id, output ready);
endinterface

interface nlr_out_if #(
  parameter int CNT_W = nlr_pkg::CNT_W
);
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] local_index;
  logic             was_new;
  logic             table_full;
  logic [CNT_W-1:0] entries_used;

  modport source (output valid, output local_index, output was_new, output table_full,
                  output entries_used, input ready);
  modport sink   (input valid, input local_index, input was_new, input table_full,
                  input entries_used, output ready);
endinterface

`default_nettype wire

// File: hdl/node_id_local_renumber_top.sv
// top level of the node id renumber block: ring of id cells plus sequencer
// from accept to result valid: a clear goes straight to the done state; a lookup scans
// a full revolution of the ring, then loads the result on a hit or a full table, or
// appends the new id first; one word in flight: the next word is taken in the cycle after
// the result loads, and a stalled result holds the sequencer until it can load
// reset empties the table (count zero) and drops any pending result word
`default_nettype none

module node_id_local_renumber_top #(
  parameter int CAPACITY = nlr_pkg::CAPACITY,
  parameter int ID_BITS  = nlr_pkg::ID_BITS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  nlr_in_if.sink    in_ch,
  nlr_out_if.source out_ch
);

  logic [ID_BITS-1:0] cell_id [CAPACITY];
  logic [ID_BITS-1:0] key;
  nlr_pkg::ring_ctl_t ctl;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_ring
      nlr_cell #(
        .ID_BITS (ID_BITS),
        .TAIL    (g == CAPACITY - 1)
      ) u_cell (
        .clk    (clk),
        .ctl    (ctl),
        .nbr_id (cell_id[(g + 1) % CAPACITY]),
        .ins_id (key),
        .id_o   (cell_id[g])
      );
    end
  endgenerate

  nlr_ctrl #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (ID_BITS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .head_id (cell_id[0]),
    .key     (key),
    .ctl     (ctl)
  );

endmodule

`default_nettype wire

// File: hdl/nlr_cell.sv
// one id cell of the rotating ring, takes its neighbor's id on shift, or the new id in the tail on insert
`default_nettype none

module nlr_cell #(
  parameter int ID_BITS = nlr_pkg::ID_BITS,
  parameter bit TAIL    = 1'b0
) (
  input  wire logic              clk,
  input  wire nlr_pkg::ring_ctl_t ctl,
  input  wire logic [ID_BITS-1:0] nbr_id,
  input  wire logic [ID_BITS-1:0] ins_id,
  output logic      [ID_BITS-1:0] id_o
);

  logic [ID_BITS-1:0] id_r;
  logic               take_ins;

  // only the tail cell receives a new id, the head's old slot wraps there
  assign take_ins = TAIL && ctl.ins;

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      id_r <= take_ins ? ins_id : nbr_id;
    end
  end

  assign id_o = id_r;

endmodule

`default_nettype wire

// File: hdl/nlr_ctrl.sv
// sequencer: head compare, entry count, ring alignment and result register
`default_nettype none
`include "node_id_local_renumber_top_assert.svh"

module nlr_ctrl #(
  parameter int CAPACITY = nlr_pkg::CAPACITY,
  parameter int ID_BITS  = nlr_pkg::ID_BITS
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  nlr_in_if.sink                  in_ch,
  nlr_out_if.source               out_ch,
  input  wire logic [ID_BITS-1:0] head_id,
  output logic      [ID_BITS-1:0] key,
  output nlr_pkg::ring_ctl_t      ctl
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int POS_W = $clog2(CAPACITY);
  localparam logic [CNT_W-1:0] CAP_C  = CNT_W'(CAPACITY);
  localparam logic [POS_W-1:0] LAST_C = POS_W'(CAPACITY - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_APPEND = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [POS_W-1:0]   hidx_r, hidx_nxt;   // entry index held by the head cell
  logic [POS_W-1:0]   stp_r, stp_nxt;
  logic               hit_r, hit_nxt;
  logic [ID_BITS-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]   res_idx_r, res_idx_nxt;
  logic               res_new_r, res_new_nxt;
  logic               res_full_r, res_full_nxt;
  logic               ov_r, ov_nxt;
  logic [CNT_W-1:0]   o_idx_r, o_idx_nxt;
  logic               o_new_r, o_new_nxt;
  logic               o_full_r, o_full_nxt;
  logic [CNT_W-1:0]   o_used_r, o_used_nxt;

  logic [CNT_W-1:0]   hidx_ext;
  logic [POS_W-1:0]   hidx_inc;
  logic               match;
  logic               last;
  logic               out_free;

  assign hidx_ext = CNT_W'(hidx_r);
  assign hidx_inc = (hidx_r == LAST_C) ? '0 : POS_W'(hidx_r + 1'b1);
  // entries at or above the count are stale and never compared
  assign match    = (head_id == key_r) && (hidx_ext < cnt_r);
  assign last     = (stp_r == LAST_C);
  assign out_free = !ov_r || out_ch.ready;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    hidx_nxt     = hidx_r;
    stp_nxt      = stp_r;
    hit_nxt      = hit_r;
    key_nxt      = key_r;
    res_idx_nxt  = res_idx_r;
    res_new_nxt  = res_new_r;
    res_full_nxt = res_full_r;
    ctl.shift    = 1'b0;
    ctl.ins      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          res_new_nxt  = 1'b0;
          res_full_nxt = 1'b0;
          if (in_ch.mode == nlr_pkg::MODE_CLEAR) begin
            cnt_nxt     = '0;
            hidx_nxt    = '0;
            res_idx_nxt = '0;
            state_nxt   = ST_DONE;
          end else begin
            key_nxt   = in_ch.node_id;
            stp_nxt   = '0;
            hit_nxt   = 1'b0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // one full revolution brings the ring back to its starting alignment
        ctl.shift = 1'b1;
        hidx_nxt  = hidx_inc;
        stp_nxt   = POS_W'(stp_r + 1'b1);
        if (match) begin
          hit_nxt     = 1'b1;
          res_idx_nxt = hidx_ext + 1'b1;
        end
        if (last) begin
          if (hit_r || match) begin
            state_nxt = ST_DONE;
          end else if (cnt_r < CAP_C) begin
            state_nxt = ST_APPEND;
          end else begin
            res_idx_nxt  = '0;
            res_full_nxt = 1'b1;
            state_nxt    = ST_DONE;
          end
        end
      end
      ST_APPEND: begin
        // head holds the free slot; it lands in the tail with the new id
        ctl.shift   = 1'b1;
        ctl.ins     = 1'b1;
        hidx_nxt    = hidx_inc;
        cnt_nxt     = cnt_r + 1'b1;
        res_idx_nxt = cnt_r + 1'b1;
        res_new_nxt = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ov_nxt     = ov_r;
    o_idx_nxt  = o_idx_r;
    o_new_nxt  = o_new_r;
    o_full_nxt = o_full_r;
    o_used_nxt = o_used_r;
    if ((state_r == ST_DONE) && out_free) begin
      ov_nxt     = 1'b1;
      o_idx_nxt  = res_idx_r;
      o_new_nxt  = res_new_r;
      o_full_nxt = res_full_r;
      o_used_nxt = cnt_r;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      hidx_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      hidx_r  <= hidx_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stp_r      <= stp_nxt;
    hit_r      <= hit_nxt;
    key_r      <= key_nxt;
    res_idx_r  <= res_idx_nxt;
    res_new_r  <= res_new_nxt;
    res_full_r <= res_full_nxt;
    o_idx_r    <= o_idx_nxt;
    o_new_r    <= o_new_nxt;
    o_full_r   <= o_full_nxt;
    o_used_r   <= o_used_nxt;
  end

  assign key                 = key_r;
  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = ov_r;
  assign out_ch.local_index  = o_idx_r;
  assign out_ch.was_new      = o_new_r;
  assign out_ch.table_full   = o_full_r;
  assign out_ch.entries_used = o_used_r;

  `NLR_ASSERT_IMP(a_idle_align, state_r == ST_IDLE, (hidx_ext == cnt_r) || ((hidx_r == '0) && (cnt_r == CAP_C)), "head cell out of step with entry count")
  `NLR_ASSERT_NXT(a_accept_busy, in_ch.valid && in_ch.ready, state_r != ST_IDLE, "accepted word left sequencer idle")
  `NLR_ASSERT_IMP(a_out_from_done, $rose(ov_r), $past(state_r == ST_DONE), "result word loaded outside done")
  `NLR_ASSERT_IMP(a_append_room, state_r == ST_APPEND, (cnt_r < CAP_C) && !hit_r, "append with full table or after hit")
  `NLR_ASSERT_IMP(a_new_xor_full, ov_r, !(o_new_r && o_full_r), "result both new and full")

endmodule

`default_nettype wire
